// ===== src/c2d_pkg.sv =====
// ----------------------------------------------------------------------------
// c2d_pkg
// Shared types and codes for the single-output-channel 2D convolution block.
// ----------------------------------------------------------------------------
package c2d_pkg;

    // Command codes
    typedef enum logic [1:0] {
        OP_FEAT = 2'd0,
        OP_WGT  = 2'd1,
        OP_CONV = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // Configuration register indexes
    localparam logic [2:0] CFG_KERNEL  = 3'd0;
    localparam logic [2:0] CFG_CHANNEL = 3'd1;
    localparam logic [2:0] CFG_HEIGHT  = 3'd2;
    localparam logic [2:0] CFG_WIDTH   = 3'd3;
    localparam logic [2:0] CFG_STEP    = 3'd4;
    localparam logic [2:0] CFG_PAD     = 3'd5;
    localparam logic [2:0] CFG_BIAS    = 3'd6;

    // Result status codes
    localparam logic ST_OK    = 1'b0;
    localparam logic ST_RANGE = 1'b1;

    // Input item
    typedef struct packed {
        t_op               op;
        logic [3:0]        channel;
        logic [5:0]        row;
        logic [5:0]        col;
        logic signed [7:0] sample;
    } t_cmd;

    // Result item
    typedef struct packed {
        logic [5:0]         out_row;
        logic [5:0]         out_col;
        logic signed [31:0] sum;
        logic               status;
    } t_res;

    // Effective (clamped) geometry
    typedef struct packed {
        logic [2:0] k;
        logic [4:0] c;
        logic [5:0] h;
        logic [5:0] w;
        logic [2:0] s;
        logic [2:0] p;
    } t_geom;

    // Token sent from the sequencer down the MAC pipeline
    typedef struct packed {
        logic clr;     // load bias into accumulator
        logic tap;     // one kernel tap
        logic in_map;  // tap lies inside the feature map
        logic fin;     // end of pixel, emit result
        logic oor;     // coordinate out of range
    } t_tap;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_FIN,
        S_WAIT
    } t_seq_state;

endpackage

// ===== src/c2d_mem.sv =====
// ----------------------------------------------------------------------------
// c2d_mem
// Feature and weight sample memories: store decode, one write and one
// registered read per memory each cycle.
// ----------------------------------------------------------------------------
module c2d_mem
    import c2d_pkg::*;
#(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_KERNEL   = 5,
    parameter int DATA_BITS    = 8
) (
    input  logic                        i_clk,
    input  logic                        i_store,
    input  t_cmd                        i_cmd,
    input  logic [FAW-1:0]              i_faddr,
    input  logic [WAW-1:0]              i_waddr,
    output logic signed [DATA_BITS-1:0] o_feat,
    output logic signed [DATA_BITS-1:0] o_wgt
);

    localparam int CB  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int HB  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WB  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int KB  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int FAW = CB + HB + WB;
    localparam int WAW = CB + 2 * KB;

    logic [DATA_BITS-1:0] r_feat_mem [2**FAW];
    logic [DATA_BITS-1:0] r_wgt_mem  [2**WAW];

    logic [7:0]           ch_ext;
    logic [7:0]           row_ext;
    logic [7:0]           col_ext;
    logic signed [15:0]   sample_ext;
    logic [DATA_BITS-1:0] wr_data;
    logic                 feat_we;
    logic                 wgt_we;
    logic [FAW-1:0]       feat_wa;
    logic [WAW-1:0]       wgt_wa;

    // Store decode and bounds check
    always_comb begin
        ch_ext     = 8'(i_cmd.channel);
        row_ext    = 8'(i_cmd.row);
        col_ext    = 8'(i_cmd.col);
        sample_ext = 16'(i_cmd.sample);
        wr_data    = sample_ext[DATA_BITS-1:0];
        feat_we    = i_store && (i_cmd.op == OP_FEAT)
                     && (32'(i_cmd.channel) < MAX_CHANNELS)
                     && (32'(i_cmd.row) < MAX_HEIGHT)
                     && (32'(i_cmd.col) < MAX_WIDTH);
        wgt_we     = i_store && (i_cmd.op == OP_WGT)
                     && (32'(i_cmd.channel) < MAX_CHANNELS)
                     && (32'(i_cmd.row) < MAX_KERNEL)
                     && (32'(i_cmd.col) < MAX_KERNEL);
        feat_wa    = {ch_ext[CB-1:0], row_ext[HB-1:0], col_ext[WB-1:0]};
        wgt_wa     = {ch_ext[CB-1:0], row_ext[KB-1:0], col_ext[KB-1:0]};
    end

    // Feature memory
    always_ff @(posedge i_clk) begin
        if (feat_we) begin
            r_feat_mem[feat_wa] <= wr_data;
        end
        o_feat <= $signed(r_feat_mem[i_faddr]);
    end

    // Weight memory
    always_ff @(posedge i_clk) begin
        if (wgt_we) begin
            r_wgt_mem[wgt_wa] <= wr_data;
        end
        o_wgt <= $signed(r_wgt_mem[i_waddr]);
    end

endmodule

// ===== src/c2d_seq.sv =====
// ----------------------------------------------------------------------------
// c2d_seq
// Pixel sequencer: range check, then one tap per cycle over channels and
// kernel rows and columns, issuing memory reads and pipeline tokens.
// ----------------------------------------------------------------------------
module c2d_seq
    import c2d_pkg::*;
#(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_KERNEL   = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  logic [5:0]     i_row,
    input  logic [5:0]     i_col,
    input  t_geom          i_geom,
    input  logic           i_done,
    output logic           o_busy,
    output t_tap           o_tap,
    output logic [FAW-1:0] o_faddr,
    output logic [WAW-1:0] o_waddr,
    output logic [5:0]     o_row,
    output logic [5:0]     o_col
);

    localparam int CB  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int HB  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WB  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int KB  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int FAW = CB + HB + WB;
    localparam int WAW = CB + 2 * KB;

    t_seq_state         r_state;
    t_seq_state         n_state;
    logic [5:0]         r_row;
    logic [5:0]         r_col;
    logic signed [10:0] r_hb;
    logic signed [10:0] r_wb;
    logic               r_oor;
    logic [4:0]         r_ci;
    logic [2:0]         r_kh;
    logic [2:0]         r_kw;

    logic signed [10:0] num_h;
    logic signed [10:0] num_w;
    logic signed [10:0] rs_h;
    logic signed [10:0] rs_w;
    logic               in_range;
    logic               no_taps;
    logic signed [10:0] ih;
    logic signed [10:0] iw;
    logic               in_map;
    logic               kw_last;
    logic               kh_last;
    logic               ci_last;
    logic               last_tap;
    logic [7:0]         ci_ext;
    logic [7:0]         kh_ext;
    logic [7:0]         kw_ext;

    // Output-size check: row < (num / s) + 1 holds exactly when row * s <= num
    always_comb begin
        num_h    = 11'(i_geom.h) + 11'({i_geom.p, 1'b0}) - 11'(i_geom.k);
        num_w    = 11'(i_geom.w) + 11'({i_geom.p, 1'b0}) - 11'(i_geom.k);
        rs_h     = $signed(11'(r_row) * 11'(i_geom.s));
        rs_w     = $signed(11'(r_col) * 11'(i_geom.s));
        in_range = !num_h[10] && !num_w[10] && (rs_h <= num_h) && (rs_w <= num_w);
        no_taps  = (i_geom.c == 5'd0) || (i_geom.k == 3'd0);
    end

    // Tap coordinates and addresses
    always_comb begin
        ih       = r_hb + $signed(11'(r_kh));
        iw       = r_wb + $signed(11'(r_kw));
        in_map   = !ih[10] && !iw[10]
                   && (ih < $signed(11'(i_geom.h))) && (iw < $signed(11'(i_geom.w)));
        kw_last  = (r_kw == 3'(i_geom.k - 3'd1));
        kh_last  = (r_kh == 3'(i_geom.k - 3'd1));
        ci_last  = (r_ci == 5'(i_geom.c - 5'd1));
        last_tap = kw_last && kh_last && ci_last;
        ci_ext   = 8'(r_ci);
        kh_ext   = 8'(r_kh);
        kw_ext   = 8'(r_kw);
        o_faddr  = {ci_ext[CB-1:0], ih[HB-1:0], iw[WB-1:0]};
        o_waddr  = {ci_ext[CB-1:0], kh_ext[KB-1:0], kw_ext[KB-1:0]};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!in_range || no_taps) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (last_tap) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_busy       = (r_state != S_IDLE);
        o_tap.clr    = (r_state == S_CHECK);
        o_tap.tap    = (r_state == S_RUN);
        o_tap.in_map = (r_state == S_RUN) && in_map;
        o_tap.fin    = (r_state == S_FIN);
        o_tap.oor    = r_oor;
        o_row        = r_row;
        o_col        = r_col;
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Coordinates, window origin and tap counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oor <= 1'b0;
            r_ci  <= '0;
            r_kh  <= '0;
            r_kw  <= '0;
        end else begin
            if (r_state == S_IDLE && i_go) begin
                r_row <= i_row;
                r_col <= i_col;
            end
            if (r_state == S_CHECK) begin
                r_hb  <= rs_h - $signed(11'(i_geom.p));
                r_wb  <= rs_w - $signed(11'(i_geom.p));
                r_oor <= !in_range;
                r_ci  <= '0;
                r_kh  <= '0;
                r_kw  <= '0;
            end else if (r_state == S_RUN) begin
                if (kw_last) begin
                    r_kw <= '0;
                    if (kh_last) begin
                        r_kh <= '0;
                        r_ci <= r_ci + 5'd1;
                    end else begin
                        r_kh <= r_kh + 3'd1;
                    end
                end else begin
                    r_kw <= r_kw + 3'd1;
                end
            end
        end
    end

endmodule

// ===== src/c2d_mac.sv =====
// ----------------------------------------------------------------------------
// c2d_mac
// Multiply-accumulate pipeline: align tokens with memory data, register the
// product, accumulate with wrap, and present the result for one cycle.
// ----------------------------------------------------------------------------
module c2d_mac
    import c2d_pkg::*;
#(
    parameter int DATA_BITS = 8,
    parameter int ACC_BITS  = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_tap                        i_tap,
    input  logic signed [DATA_BITS-1:0] i_feat,
    input  logic signed [DATA_BITS-1:0] i_wgt,
    input  logic signed [31:0]          i_bias,
    input  logic [5:0]                  i_row,
    input  logic [5:0]                  i_col,
    output logic                        o_valid,
    output t_res                        o_res
);

    t_tap                            r_tap_a;
    t_tap                            r_tap_b;
    logic signed [2*DATA_BITS-1:0]   r_prod;
    logic signed [ACC_BITS-1:0]      r_acc;

    logic signed [2*DATA_BITS-1:0]   mul;
    logic signed [63:0]              prod_w;
    logic signed [63:0]              bias_w;
    logic signed [63:0]              acc_w;

    // Widening for wrap arithmetic
    always_comb begin
        mul    = i_feat * i_wgt;
        prod_w = 64'(r_prod);
        bias_w = 64'(i_bias);
        acc_w  = 64'(r_acc);
    end

    // Token pipeline: stage A meets read data, stage B meets the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_a <= '0;
            r_tap_b <= '0;
            o_valid <= 1'b0;
        end else begin
            r_tap_a <= i_tap;
            r_tap_b <= r_tap_a;
            o_valid <= r_tap_b.fin;
        end
    end

    // Product register, padding taps give zero
    always_ff @(posedge i_clk) begin
        if (r_tap_a.in_map) begin
            r_prod <= mul;
        end else begin
            r_prod <= '0;
        end
    end

    // Accumulator and result register
    always_ff @(posedge i_clk) begin
        if (r_tap_b.clr) begin
            r_acc <= bias_w[ACC_BITS-1:0];
        end else if (r_tap_b.tap) begin
            r_acc <= r_acc + prod_w[ACC_BITS-1:0];
        end
        if (r_tap_b.fin) begin
            o_res.out_row <= i_row;
            o_res.out_col <= i_col;
            if (r_tap_b.oor) begin
                o_res.sum    <= '0;
                o_res.status <= ST_RANGE;
            end else begin
                o_res.sum    <= acc_w[31:0];
                o_res.status <= ST_OK;
            end
        end
    end

endmodule

// ===== src/conv2d_single_output_channel.sv =====
// ----------------------------------------------------------------------------
// conv2d_single_output_channel
// Direct 2D convolution with stride and zero padding, one output channel.
//
// Commands arrive on i_cmd and transfer when start is high and busy is low.
// Store-feature and store-weight commands write one signed sample into the
// feature or weight memory at that edge; they never raise busy, so stores
// can transfer every cycle while busy is low. A compute command names an
// output pixel; busy rises for the whole pixel and the result appears on
// o_res for one cycle with o_valid high. Per pixel the sequencer runs a check
// state, every tap of the C channels and K x K kernel in use, then a finish
// state; the finish token passes MAC stages A and B to the o_valid register,
// and busy falls in the cycle after o_valid. Out-of-range pixels skip taps.
// The single MAC takes one tap per cycle from the two sample memories.
// Configuration writes take effect at once and belong in idle periods.
// Reset restores the register defaults and clears the control pipeline; the
// sample memories are not cleared and must be written before they are read.
// The receiver cannot stall: each result is present for exactly one cycle.
// ----------------------------------------------------------------------------
module conv2d_single_output_channel
    import c2d_pkg::*;
#(
    parameter int MAX_CHANNELS = 16,
    parameter int MAX_HEIGHT   = 32,
    parameter int MAX_WIDTH    = 32,
    parameter int MAX_KERNEL   = 5,
    parameter int DATA_BITS    = 8,
    parameter int ACC_BITS     = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    output t_res        o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam int CB  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int HB  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WB  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int KB  = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int FAW = CB + HB + WB;
    localparam int WAW = CB + 2 * KB;

    logic [2:0]         r_kernel;
    logic [4:0]         r_channel;
    logic [5:0]         r_height;
    logic [5:0]         r_width;
    logic [2:0]         r_step;
    logic [2:0]         r_pad;
    logic signed [31:0] r_bias;

    t_geom                       geom;
    logic                        accept;
    logic                        go;
    t_tap                        tap;
    logic [FAW-1:0]              faddr;
    logic [WAW-1:0]              waddr;
    logic signed [DATA_BITS-1:0] feat;
    logic signed [DATA_BITS-1:0] wgt;
    logic [5:0]                  pix_row;
    logic [5:0]                  pix_col;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel  <= 3'd3;
            r_channel <= 5'd1;
            r_height  <= 6'd32;
            r_width   <= 6'd32;
            r_step    <= 3'd1;
            r_pad     <= 3'd0;
            r_bias    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KERNEL:  r_kernel  <= i_cfg_data[2:0];
                CFG_CHANNEL: r_channel <= i_cfg_data[4:0];
                CFG_HEIGHT:  r_height  <= i_cfg_data[5:0];
                CFG_WIDTH:   r_width   <= i_cfg_data[5:0];
                CFG_STEP:    r_step    <= i_cfg_data[2:0];
                CFG_PAD:     r_pad     <= i_cfg_data[2:0];
                CFG_BIAS:    r_bias    <= $signed(i_cfg_data);
                default:     ;
            endcase
        end
    end

    // Effective geometry: clamp to the memory sizes, zero stride acts as one
    always_comb begin
        geom.k = (32'(r_kernel) > MAX_KERNEL) ? 3'(MAX_KERNEL) : r_kernel;
        geom.c = (32'(r_channel) > MAX_CHANNELS) ? 5'(MAX_CHANNELS) : r_channel;
        geom.h = (32'(r_height) > MAX_HEIGHT) ? 6'(MAX_HEIGHT) : r_height;
        geom.w = (32'(r_width) > MAX_WIDTH) ? 6'(MAX_WIDTH) : r_width;
        geom.s = (r_step == 3'd0) ? 3'd1 : r_step;
        geom.p = r_pad;
    end

    // Command transfer
    assign accept = start && !busy;
    assign go     = accept && (i_cmd.op == OP_CONV);

    c2d_mem #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_KERNEL   (MAX_KERNEL),
        .DATA_BITS    (DATA_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_store (accept),
        .i_cmd   (i_cmd),
        .i_faddr (faddr),
        .i_waddr (waddr),
        .o_feat  (feat),
        .o_wgt   (wgt)
    );

    c2d_seq #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_KERNEL   (MAX_KERNEL)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_row   (i_cmd.row),
        .i_col   (i_cmd.col),
        .i_geom  (geom),
        .i_done  (o_valid),
        .o_busy  (busy),
        .o_tap   (tap),
        .o_faddr (faddr),
        .o_waddr (waddr),
        .o_row   (pix_row),
        .o_col   (pix_col)
    );

    c2d_mac #(
        .DATA_BITS (DATA_BITS),
        .ACC_BITS  (ACC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tap   (tap),
        .i_feat  (feat),
        .i_wgt   (wgt),
        .i_bias  (r_bias),
        .i_row   (pix_row),
        .i_col   (pix_col),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    // A result only ends a pixel that was in progress
    a_valid_in_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe outside a pixel");

    // Out-of-range pixels report a zero sum
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.status == ST_RANGE)) |-> (o_res.sum == '0))
        else $error("out-of-range result with nonzero sum");

    // A compute transfer holds off the next command
    a_conv_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> busy)
        else $error("compute transfer did not raise busy");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the single-output-channel 2D convolution block.
// Fills both sample memories, then runs directed geometry and store cases and
// randomized traffic over many register settings. A local predictor tracks
// the memories and registers and queues the expected pixel for every compute
// transfer; a checker compares each strobed result against the queue head.
// ----------------------------------------------------------------------------
module tb;
    import c2d_pkg::*;

    localparam int FEAT_CH   = 16;
    localparam int FEAT_ROWS = 32;
    localparam int FEAT_COLS = 32;
    localparam int KERN_MAX  = 5;
    localparam int CYCLE_LIMIT = 1_500_000;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    t_cmd        i_cmd      = '0;
    logic        o_valid;
    t_res        o_res;
    logic        i_cfg_we   = 1'b0;
    logic [2:0]  i_cfg_idx  = CFG_KERNEL;
    logic [31:0] i_cfg_data = '0;

    conv2d_single_output_channel i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_cmd     (i_cmd),
        .o_valid   (o_valid),
        .o_res     (o_res),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Predictor state: registers at reset values, shadow sample memories
    logic [2:0]  cfg_kernel  = 3'd3;
    logic [4:0]  cfg_chans   = 5'd1;
    logic [5:0]  cfg_height  = 6'd32;
    logic [5:0]  cfg_width   = 6'd32;
    logic [2:0]  cfg_step    = 3'd1;
    logic [2:0]  cfg_pad     = 3'd0;
    logic [31:0] cfg_bias    = '0;

    logic signed [7:0] feat_mem [FEAT_CH][FEAT_ROWS][FEAT_COLS];
    logic signed [7:0] wgt_mem  [FEAT_CH][KERN_MAX][KERN_MAX];

    t_res pending_pixels [$];
    int   mismatch_cnt = 0;
    int   cycle_cnt    = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[conv2d_single_output_channel] ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // ---------------------------------------------------------------- predictor
    function automatic int eff_kernel();
        return (cfg_kernel > KERN_MAX) ? KERN_MAX : int'(cfg_kernel);
    endfunction

    function automatic int eff_step();
        return (cfg_step == 0) ? 1 : int'(cfg_step);
    endfunction

    // Output extent along one axis; floor division, zero when kernel overhangs
    function automatic int out_extent(input int size_reg, input int size_max);
        int sz;
        int span;
        sz   = (size_reg > size_max) ? size_max : size_reg;
        span = sz + 2 * int'(cfg_pad) - eff_kernel();
        return (span < 0) ? 0 : span / eff_step() + 1;
    endfunction

    function automatic t_res conv_pixel(input logic [5:0] r, input logic [5:0] c);
        int   k, nch, h, w, s, hb, wb, ih, iw;
        int   acc;
        t_res res;
        k   = eff_kernel();
        s   = eff_step();
        nch = (cfg_chans > FEAT_CH) ? FEAT_CH : int'(cfg_chans);
        h   = (cfg_height > FEAT_ROWS) ? FEAT_ROWS : int'(cfg_height);
        w   = (cfg_width > FEAT_COLS) ? FEAT_COLS : int'(cfg_width);
        res.out_row = r;
        res.out_col = c;
        if (int'(r) >= out_extent(cfg_height, FEAT_ROWS) ||
            int'(c) >= out_extent(cfg_width, FEAT_COLS)) begin
            res.sum    = '0;
            res.status = ST_RANGE;
            return res;
        end
        // 32-bit int wraps like the accumulator
        acc = $signed(cfg_bias);
        hb  = int'(r) * s - int'(cfg_pad);
        wb  = int'(c) * s - int'(cfg_pad);
        for (int ci = 0; ci < nch; ci++)
            for (int kh = 0; kh < k; kh++)
                for (int kw = 0; kw < k; kw++) begin
                    ih = hb + kh;
                    iw = wb + kw;
                    if (ih >= 0 && ih < h && iw >= 0 && iw < w)
                        acc = acc + int'(feat_mem[ci][ih][iw]) * int'(wgt_mem[ci][kh][kw]);
                end
        res.sum    = acc;
        res.status = ST_OK;
        return res;
    endfunction

    // Track the effect of one accepted command
    function automatic void track_cmd(input t_cmd c);
        case (c.op)
            OP_FEAT: begin
                if (c.row < FEAT_ROWS && c.col < FEAT_COLS)
                    feat_mem[c.channel][c.row][c.col] = c.sample;
            end
            OP_WGT: begin
                if (c.row < KERN_MAX && c.col < KERN_MAX)
                    wgt_mem[c.channel][c.row][c.col] = c.sample;
            end
            OP_CONV: pending_pixels.push_back(conv_pixel(c.row, c.col));
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- checker
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result (%0d,%0d) sum %0d",
                                          o_res.out_row, o_res.out_col, o_res.sum));
            end else begin
                want = pending_pixels.pop_front();
                if (o_res.out_row !== want.out_row)
                    report_mismatch($sformatf("out_row %0d, want %0d",
                                              o_res.out_row, want.out_row));
                if (o_res.out_col !== want.out_col)
                    report_mismatch($sformatf("out_col %0d, want %0d",
                                              o_res.out_col, want.out_col));
                if (o_res.sum !== want.sum)
                    report_mismatch($sformatf("sum at (%0d,%0d) %0d, want %0d",
                                              want.out_row, want.out_col,
                                              o_res.sum, want.sum));
                if (o_res.status !== want.status)
                    report_mismatch($sformatf("status at (%0d,%0d) %0b, want %0b",
                                              want.out_row, want.out_col,
                                              o_res.status, want.status));
            end
        end
    end

    // ---------------------------------------------------------------- drivers
    function automatic t_cmd make_cmd(input t_op op, input logic [3:0] ch,
                                      input logic [5:0] r, input logic [5:0] c,
                                      input logic [7:0] smp);
        t_cmd cmd;
        cmd.op      = op;
        cmd.channel = ch;
        cmd.row     = r;
        cmd.col     = c;
        cmd.sample  = smp;
        return cmd;
    endfunction

    // Leaves start high so back-to-back transfers need no toggle
    task automatic send_cmd(input t_cmd c);
        i_cmd <= c;
        start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        track_cmd(c);
    endtask

    task automatic stall_for(input int n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Hold off until every pixel is back and the block has gone idle
    task automatic wait_results_done();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_pixels.size() != 0 || busy) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_KERNEL:  cfg_kernel = data[2:0];
            CFG_CHANNEL: cfg_chans  = data[4:0];
            CFG_HEIGHT:  cfg_height = data[5:0];
            CFG_WIDTH:   cfg_width  = data[5:0];
            CFG_STEP:    cfg_step   = data[2:0];
            CFG_PAD:     cfg_pad    = data[2:0];
            CFG_BIAS:    cfg_bias   = data;
            default: ;
        endcase
    endtask

    // Rewrites every register, always from an idle block
    task automatic apply_config(input int k, input int ch, input int h, input int w,
                                input int s, input int p, input logic [31:0] bias);
        wait_results_done();
        cfg_write(CFG_KERNEL, k);
        cfg_write(CFG_CHANNEL, ch);
        cfg_write(CFG_HEIGHT, h);
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_STEP, s);
        cfg_write(CFG_PAD, p);
        cfg_write(CFG_BIAS, bias);
        i_cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------- tests
    // Every memory entry gets written before any compute can read it
    task automatic load_all_stores();
        for (int ch = 0; ch < FEAT_CH; ch++) begin
            for (int r = 0; r < KERN_MAX; r++)
                for (int c = 0; c < KERN_MAX; c++)
                    send_cmd(make_cmd(OP_WGT, ch, r, c, $urandom));
            for (int r = 0; r < FEAT_ROWS; r++)
                for (int c = 0; c < FEAT_COLS; c++)
                    send_cmd(make_cmd(OP_FEAT, ch, r, c, $urandom));
        end
        stall_for(1);
    endtask

    // Register defaults: 3x3 kernel, one channel, 32x32, 30x30 output
    task automatic test_reset_defaults();
        send_cmd(make_cmd(OP_CONV, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_CONV, 0, 29, 29, 0));
        stall_for(3);
        send_cmd(make_cmd(OP_CONV, 0, 30, 5, 0));
        send_cmd(make_cmd(OP_CONV, 0, 5, 30, 0));
        send_cmd(make_cmd(OP_NONE, 4'hF, 6'h3F, 6'h3F, 8'hFF));
        send_cmd(make_cmd(OP_CONV, 0, 63, 63, 0));
        stall_for(1);
    endtask

    // Sample extremes and stores past the memory bounds
    task automatic test_store_cases();
        send_cmd(make_cmd(OP_FEAT, 15, 31, 31, 8'h80));
        send_cmd(make_cmd(OP_FEAT, 0, 0, 0, 8'h7F));
        send_cmd(make_cmd(OP_FEAT, 0, 32, 0, 8'h37));
        send_cmd(make_cmd(OP_WGT, 0, 0, 0, 8'h80));
        send_cmd(make_cmd(OP_WGT, 0, 5, 0, 8'h11));
        send_cmd(make_cmd(OP_WGT, 0, 0, 63, 8'h22));
        send_cmd(make_cmd(OP_CONV, 0, 0, 0, 0));
        stall_for(1);
    endtask

    // Accumulator wrap in both directions through a 1x1 kernel
    task automatic test_acc_wrap();
        apply_config(1, 1, 32, 32, 1, 0, 32'h7FFF_FFFF);
        send_cmd(make_cmd(OP_FEAT, 0, 0, 0, 8'h7F));
        send_cmd(make_cmd(OP_WGT, 0, 0, 0, 8'h7F));
        send_cmd(make_cmd(OP_CONV, 0, 0, 0, 0));
        apply_config(1, 1, 32, 32, 1, 0, 32'h8000_0000);
        send_cmd(make_cmd(OP_WGT, 0, 0, 0, 8'h80));
        send_cmd(make_cmd(OP_CONV, 0, 0, 0, 0));
    endtask

    // Smallest, largest, oversized and degenerate geometries
    task automatic test_geometry_extremes();
        apply_config(1, 1, 1, 1, 1, 0, 32'd0);
        send_cmd(make_cmd(OP_CONV, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_CONV, 0, 0, 1, 0));
        // 9x9 output
        apply_config(5, 16, 32, 32, 4, 4, $urandom);
        send_cmd(make_cmd(OP_CONV, 0, 8, 8, 0));
        send_cmd(make_cmd(OP_CONV, 0, 9, 0, 0));
        // saturating registers, zero stride acting as one
        apply_config(7, 31, 63, 63, 0, 7, 32'h8000_0000);
        send_cmd(make_cmd(OP_CONV, 0, 41, 41, 0));
        send_cmd(make_cmd(OP_CONV, 0, 42, 0, 0));
        send_cmd(make_cmd(OP_CONV, 0, 0, 0, 0));
        // no taps summed: bias only
        apply_config(0, 16, 32, 32, 1, 0, 32'h1234_5678);
        send_cmd(make_cmd(OP_CONV, 0, 3, 3, 0));
        apply_config(3, 0, 32, 32, 1, 2, 32'hFEDC_BA98);
        send_cmd(make_cmd(OP_CONV, 0, 1, 2, 0));
        // kernel larger than the padded map
        apply_config(5, 1, 2, 3, 1, 1, 32'd7);
        send_cmd(make_cmd(OP_CONV, 0, 0, 0, 0));
    endtask

    task automatic random_item();
        t_cmd c;
        int   sel;
        int   rows_out;
        int   cols_out;
        c.channel = $urandom;
        c.row     = $urandom;
        c.col     = $urandom;
        c.sample  = $urandom;
        sel       = $urandom_range(0, 99);
        rows_out  = out_extent(cfg_height, FEAT_ROWS);
        cols_out  = out_extent(cfg_width, FEAT_COLS);
        if (sel < 45) begin
            c.op = OP_CONV;
            if (rows_out > 0 && cols_out > 0) begin
                c.row = $urandom_range(0, rows_out - 1);
                c.col = $urandom_range(0, cols_out - 1);
            end
        end else if (sel < 55) begin
            c.op = OP_CONV;
        end else if (sel < 75) begin
            c.op = OP_FEAT;
            if (sel < 72) begin
                c.row = $urandom_range(0, FEAT_ROWS - 1);
                c.col = $urandom_range(0, FEAT_COLS - 1);
            end
        end else if (sel < 97) begin
            c.op = OP_WGT;
            if (sel < 92) begin
                c.row = $urandom_range(0, KERN_MAX - 1);
                c.col = $urandom_range(0, KERN_MAX - 1);
            end
        end else begin
            c.op = OP_NONE;
        end
        send_cmd(c);
    endtask

    // Random settings per phase, mostly small channel counts
    task automatic test_random_traffic();
        int  ch;
        int  h;
        int  w;
        bit  no_gaps;
        for (int phase = 0; phase < 8; phase++) begin
            ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
            h  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 32) : $urandom_range(0, 63);
            w  = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 32) : $urandom_range(0, 63);
            apply_config($urandom_range(0, 7), ch, h, w, $urandom_range(0, 7),
                         $urandom_range(0, 7), $urandom);
            no_gaps = (phase % 4 == 1);
            for (int n = 0; n < 68; n++) begin
                random_item();
                if (phase == 3 && n == 30)
                    wait_results_done();
                else if (!no_gaps)
                    stall_for(pick_gap());
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_all_stores();
        test_reset_defaults();
        test_store_cases();
        test_acc_wrap();
        test_geometry_extremes();
        test_random_traffic();

        wait_results_done();
        repeat (8) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("[conv2d_single_output_channel] OK");
        else
            $display("[conv2d_single_output_channel] ERROR");
        $finish;
    end

endmodule

// ===== conv2d_single_output_channel.f =====
src/c2d_pkg.sv
src/c2d_mem.sv
src/c2d_seq.sv
src/c2d_mac.sv
src/conv2d_single_output_channel.sv
tb/sv/tb.sv
